[src/fstp_pkg.sv]
`default_nettype none

package fstp_pkg;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  task_req;
        logic [47:0] timestamp;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  task_out;
        logic [31:0] call_count;
        logic [47:0] self_ticks;
        logic [6:0]  stack_level;
    } t_out;

    localparam logic [1:0] FUNC_START    = 2'd0;
    localparam logic [1:0] FUNC_COMPLETE = 2'd1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic look;
        logic calc;
        logic upd;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic go_calc;
    } t_sts;

endpackage

`default_nettype wire

[src/fstp_ctrl.sv]
`default_nettype none

module fstp_ctrl
    import fstp_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LOOK  = 6'b000100,
        S_CALC  = 6'b001000,
        S_UPD   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = i_sts.go_calc ? S_CALC : S_DONE;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[src/fstp_dp.sv]
`default_nettype none

module fstp_dp
    import fstp_pkg::*;
#(
    parameter int NUM_TASKS   = 256,
    parameter int STACK_DEPTH = 64
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_cmd i_cmd,
    input  t_in  i_in_data,
    output t_sts o_sts,
    output t_out o_out_data
);

    localparam int TI_W  = $clog2(NUM_TASKS);
    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int LVL_W = $clog2(STACK_DEPTH + 1);

    // task number to table index
    logic [TI_W-1:0] w_mod [256];
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign w_mod[g] = TI_W'(g % NUM_TASKS);
    end

    // per-task table
    logic [31:0] r_cnt_mem  [NUM_TASKS];
    logic [47:0] r_self_mem [NUM_TASKS];
    // frame stack
    logic [7:0]  r_ftask_mem  [STACK_DEPTH];
    logic [47:0] r_fstart_mem [STACK_DEPTH];
    logic [47:0] r_fov_mem    [STACK_DEPTH];

    t_in              r_item;
    logic [LVL_W-1:0] r_level;
    logic [TI_W-1:0]  r_clr_idx;
    logic [31:0]      r_cnt_rd;
    logic [47:0]      r_self_rd;
    logic [7:0]       r_ftask_rd;
    logic [47:0]      r_fstart_rd;
    logic [47:0]      r_fov_top_rd;
    logic [47:0]      r_fov_par_rd;
    logic [47:0]      r_elapsed;
    logic [47:0]      r_delta;
    logic [47:0]      r_pov_new;
    t_out             r_res;
    t_out             r_out;

    logic [SP_W-1:0]  w_top_addr, w_par_addr, w_push_addr;
    logic             w_full, w_go_calc, w_push, w_par_we;
    logic [TI_W-1:0]  w_tbl_raddr, w_tbl_waddr;
    logic             w_tbl_we;
    logic [31:0]      w_cnt_wd, w_cnt_new;
    logic [47:0]      w_self_wd, w_self_new;
    logic             w_fov_we;
    logic [SP_W-1:0]  w_fov_waddr;
    logic [47:0]      w_fov_wd;
    logic [48:0]      w_diff, w_psum, w_ssum;
    t_out             w_look_res, w_upd_res;

    assign w_top_addr  = SP_W'(r_level - LVL_W'(1));
    assign w_par_addr  = SP_W'(r_level - LVL_W'(2));
    assign w_push_addr = SP_W'(r_level);

    assign w_full    = (r_level == LVL_W'(STACK_DEPTH));
    assign w_go_calc = (r_item.func == FUNC_COMPLETE) && (r_level != '0);
    assign w_push    = i_cmd.look && (r_item.func == FUNC_START) && !w_full;
    assign w_par_we  = i_cmd.upd && (r_level > LVL_W'(1));

    assign o_sts.clr_last = (r_clr_idx == TI_W'(NUM_TASKS - 1));
    assign o_sts.go_calc  = w_go_calc;

    // table ports
    assign w_tbl_raddr = i_cmd.look ? w_mod[r_ftask_rd] : w_mod[i_in_data.task_req];
    assign w_tbl_we    = i_cmd.clear || i_cmd.upd;
    assign w_tbl_waddr = i_cmd.clear ? r_clr_idx : w_mod[r_ftask_rd];
    assign w_cnt_wd    = i_cmd.clear ? '0 : w_cnt_new;
    assign w_self_wd   = i_cmd.clear ? '0 : w_self_new;

    // overlap write port: zero on push, parent update on pop
    assign w_fov_we    = w_push || w_par_we;
    assign w_fov_waddr = w_push ? w_push_addr : w_par_addr;
    assign w_fov_wd    = w_push ? '0 : r_pov_new;

    // arithmetic
    assign w_diff     = {1'b0, r_elapsed} - {1'b0, r_fov_top_rd};
    assign w_psum     = {1'b0, r_fov_par_rd} + {1'b0, r_elapsed};
    assign w_ssum     = {1'b0, r_self_rd} + {1'b0, r_delta};
    assign w_self_new = w_ssum[48] ? MAX48 : w_ssum[47:0];
    assign w_cnt_new  = (r_cnt_rd == MAX32) ? r_cnt_rd : r_cnt_rd + 32'd1;

    always_comb begin
        w_look_res.status      = STATUS_OK;
        w_look_res.task_out    = r_item.task_req;
        w_look_res.call_count  = r_cnt_rd;
        w_look_res.self_ticks  = r_self_rd;
        w_look_res.stack_level = 7'(r_level);
        case (r_item.func)
            FUNC_START: begin
                if (w_full) w_look_res.status = STATUS_FULL;
                else        w_look_res.stack_level = 7'(r_level + LVL_W'(1));
            end
            FUNC_COMPLETE: begin
                // only reaches here with an empty stack
                w_look_res        = '0;
                w_look_res.status = STATUS_EMPTY;
            end
            default: ;
        endcase
    end

    always_comb begin
        w_upd_res.status      = STATUS_OK;
        w_upd_res.task_out    = r_ftask_rd;
        w_upd_res.call_count  = w_cnt_new;
        w_upd_res.self_ticks  = w_self_new;
        w_upd_res.stack_level = 7'(r_level - LVL_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_cnt_mem[w_tbl_waddr]  <= w_cnt_wd;
            r_self_mem[w_tbl_waddr] <= w_self_wd;
        end
        if (i_cmd.accept || i_cmd.look) begin
            r_cnt_rd  <= r_cnt_mem[w_tbl_raddr];
            r_self_rd <= r_self_mem[w_tbl_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ftask_mem[w_push_addr]  <= r_item.task_req;
            r_fstart_mem[w_push_addr] <= r_item.timestamp;
        end
        if (w_fov_we) begin
            r_fov_mem[w_fov_waddr] <= w_fov_wd;
        end
        if (i_cmd.accept) begin
            r_ftask_rd   <= r_ftask_mem[w_top_addr];
            r_fstart_rd  <= r_fstart_mem[w_top_addr];
            r_fov_top_rd <= r_fov_mem[w_top_addr];
            r_fov_par_rd <= r_fov_mem[w_par_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_item <= i_in_data;
        if (i_cmd.look) r_elapsed <= r_item.timestamp - r_fstart_rd;
        if (i_cmd.calc) begin
            r_delta   <= w_diff[48] ? '0 : w_diff[47:0];
            r_pov_new <= w_psum[48] ? MAX48 : w_psum[47:0];
        end
        if (i_cmd.look && !w_go_calc) r_res <= w_look_res;
        if (i_cmd.upd) r_res <= w_upd_res;
        if (i_cmd.load_out) r_out <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= '0;
            r_clr_idx <= '0;
        end else begin
            if (i_cmd.clear) r_clr_idx <= r_clr_idx + TI_W'(1);
            if (w_push) r_level <= r_level + LVL_W'(1);
            else if (i_cmd.upd) r_level <= r_level - LVL_W'(1);
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

[src/flat_self_time_profiler.sv]
// steps per beat: accept (stack read), look (elapsed); start, read and error beats
// then go to done, a complete with frames on the stack passes calc (delta) and update
// (table update) first; a new beat is taken only in idle, after the last one is done;
// one result may wait in the output register, a second one holds the block in its
// last step with ready low
// reset: a clearing pass zeroes the task table with ready low; the frame stack is
// not cleared, only the level resets to zero
`default_nettype none

module flat_self_time_profiler
    import fstp_pkg::*;
#(
    parameter int NUM_TASKS   = 256,
    parameter int STACK_DEPTH = 64
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  wire  i_out_ready,
    output t_out o_out_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    fstp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    fstp_dp #(
        .NUM_TASKS   (NUM_TASKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

[verif/flat_self_time_profiler_tb.sv]
`timescale 1ns / 100ps

module flat_self_time_profiler_tb;
    import fstp_pkg::*;

    localparam int NUM_TASKS   = 256;
    localparam int STACK_DEPTH = 64;
    localparam int ITEMS       = 1250;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SINK_HOLD   = 400;
    localparam int MAX_REPORTS = 10;

    // func codes the package leaves unnamed
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef enum {SEQ_CALLS, SEQ_READS, SEQ_NOISE, SEQ_DIVE, SEQ_UNWIND} t_seq_kind;

    class self_time_board;
        logic [31:0] call_tab [NUM_TASKS];
        logic [47:0] self_tab [NUM_TASKS];
        logic [7:0]  fr_task  [STACK_DEPTH];
        logic [47:0] fr_start [STACK_DEPTH];
        logic [47:0] fr_ovl   [STACK_DEPTH];
        int unsigned level;
        t_out        expected_q [$];
        int unsigned errors, checked;
        int unsigned n_start, n_complete, n_read, n_full, n_empty, n_capped, deepest;

        function new();
            foreach (call_tab[i]) begin
                call_tab[i] = '0;
                self_tab[i] = '0;
            end
            level = 0;
            errors = 0;
            checked = 0;
            n_start = 0;
            n_complete = 0;
            n_read = 0;
            n_full = 0;
            n_empty = 0;
            n_capped = 0;
            deepest = 0;
        endfunction

        function logic [47:0] sum_capped(logic [47:0] a, logic [47:0] b);
            logic [48:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (s[48]) begin
                n_capped++;
                return MAX48;
            end
            return s[47:0];
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("%s", msg);
        endfunction

        // update the profile for one accepted event and queue its result
        function void note_input(t_in beat);
            t_out        res;
            int unsigned idx, top;
            logic [47:0] elapsed, delta;
            res = '0;
            idx = beat.task_req % NUM_TASKS;
            case (beat.func)
                FUNC_START: begin
                    n_start++;
                    if (level < STACK_DEPTH) begin
                        fr_task[level]  = beat.task_req;
                        fr_start[level] = beat.timestamp;
                        fr_ovl[level]   = '0;
                        level++;
                        res.status = STATUS_OK;
                    end else begin
                        res.status = STATUS_FULL;
                        n_full++;
                    end
                    res.task_out    = beat.task_req;
                    res.call_count  = call_tab[idx];
                    res.self_ticks  = self_tab[idx];
                    res.stack_level = 7'(level);
                end
                FUNC_COMPLETE: begin
                    n_complete++;
                    if (level == 0) begin
                        res.status = STATUS_EMPTY;
                        n_empty++;
                    end else begin
                        top     = level - 1;
                        idx     = fr_task[top] % NUM_TASKS;
                        elapsed = beat.timestamp - fr_start[top];
                        // children may have taken longer than the frame itself
                        delta   = (elapsed > fr_ovl[top]) ? elapsed - fr_ovl[top] : '0;
                        if (call_tab[idx] != MAX32) call_tab[idx] = call_tab[idx] + 1;
                        self_tab[idx] = sum_capped(self_tab[idx], delta);
                        level = top;
                        if (level > 0) fr_ovl[level - 1] = sum_capped(fr_ovl[level - 1], elapsed);
                        res.status      = STATUS_OK;
                        res.task_out    = fr_task[top];
                        res.call_count  = call_tab[idx];
                        res.self_ticks  = self_tab[idx];
                        res.stack_level = 7'(level);
                    end
                end
                default: begin
                    n_read++;
                    res.status      = STATUS_OK;
                    res.task_out    = beat.task_req;
                    res.call_count  = call_tab[idx];
                    res.self_ticks  = self_tab[idx];
                    res.stack_level = 7'(level);
                end
            endcase
            if (level > deepest) deepest = level;
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected result: status %0d task %0d level %0d",
                               got.status, got.task_out, got.stack_level));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.status !== want.status || got.task_out !== want.task_out ||
                got.call_count !== want.call_count || got.self_ticks !== want.self_ticks ||
                got.stack_level !== want.stack_level) begin
                flag($sformatf({"mismatch at result %0d (expected/actual): status %0d/%0d ",
                                "task %0d/%0d count %0d/%0d self %0d/%0d level %0d/%0d"},
                               checked, want.status, got.status, want.task_out, got.task_out,
                               want.call_count, got.call_count, want.self_ticks,
                               got.self_ticks, want.stack_level, got.stack_level));
            end
        endfunction

        function void finish_check();
            if (expected_q.size() != 0)
                flag($sformatf("%0d results never arrived", expected_q.size()));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;

    self_time_board sb;
    int unsigned    items_sent = 0;
    int unsigned    cycle_count = 0;
    logic [47:0]    tick_now = '0;
    bit             steady = 1'b0;

    flat_self_time_profiler #(
        .NUM_TASKS   (NUM_TASKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("flat_self_time_profiler_tb: errors");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    end

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    // mostly forward steps, rarely a step back or a jump anywhere
    function automatic logic [47:0] next_stamp();
        int unsigned pick;
        pick = $urandom_range(0, 199);
        if (pick < 197) tick_now = tick_now + 48'($urandom_range(0, 3000));
        else if (pick < 198) tick_now = tick_now - 48'($urandom_range(1, 500));
        else tick_now = rand48();
        return tick_now;
    endfunction

    function automatic logic [7:0] pick_task();
        if ($urandom_range(0, 99) < 70) return 8'($urandom_range(0, 63));
        return 8'($urandom_range(0, 255));
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_item(input logic [1:0] func, input logic [7:0] task_id,
                             input logic [47:0] stamp);
        t_in beat;
        beat.func      = func;
        beat.task_req  = task_id;
        beat.timestamp = stamp;
        steady = (items_sent >= 900 && items_sent < 1050);
        while (!steady && $urandom_range(0, 99) < 28) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(beat);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    initial begin : sink
        int unsigned hold;
        bit          held_once;
        hold = 0;
        held_once = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            // one long back-pressure stretch so the block fills and stalls its input
            if (!held_once && sb.checked >= 300) begin
                held_once = 1'b1;
                hold = SINK_HOLD;
            end
            if (hold > 0) begin
                out_ready <= 1'b0;
                hold--;
            end else begin
                out_ready <= steady || ($urandom_range(0, 99) >= 28);
            end
        end
    end

    initial begin : source
        t_seq_kind   kind;
        int unsigned seq_no, pick, n;
        bit          paused_once;
        sb = new();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reads of a cleared table, unused func code, complete on empty stack
        send_item(FUNC_READ, 8'd0, 48'd0);
        send_item(FUNC_UNUSED, 8'd255, MAX48);
        send_item(FUNC_COMPLETE, 8'hAA, 48'h5555_AAAA_5555);
        // nested calls across the timestamp wrap, parent overlap beats its elapsed
        send_item(FUNC_START, 8'd255, MAX48 - 48'd5);
        send_item(FUNC_START, 8'd0, MAX48 - 48'd2);
        send_item(FUNC_COMPLETE, 8'h55, 48'd3);
        send_item(FUNC_COMPLETE, 8'h00, MAX48 - 48'd4);
        send_item(FUNC_READ, 8'd255, 48'd0);
        // self time saturation
        send_item(FUNC_START, 8'h5A, 48'd1);
        send_item(FUNC_COMPLETE, 8'hFF, 48'd0);
        send_item(FUNC_START, 8'h5A, 48'd1);
        send_item(FUNC_COMPLETE, 8'hFF, 48'd0);
        // parent overlap saturation
        send_item(FUNC_START, 8'h33, 48'd1);
        send_item(FUNC_START, 8'h34, 48'd2);
        send_item(FUNC_COMPLETE, 8'd0, 48'd1);
        send_item(FUNC_START, 8'h34, 48'd2);
        send_item(FUNC_COMPLETE, 8'd0, 48'd1);
        send_item(FUNC_COMPLETE, 8'd0, 48'd0);
        send_item(FUNC_UNUSED, 8'h33, 48'd7);
        send_item(FUNC_READ, 8'h5A, 48'd9);
        wait_drained();
        @(negedge clk);

        tick_now = rand48();
        seq_no = 0;
        paused_once = 1'b0;
        while (items_sent < ITEMS) begin
            pick = $urandom_range(0, 99);
            if (seq_no == 0 || seq_no == 60) kind = SEQ_DIVE;
            else if (pick < 70) kind = SEQ_CALLS;
            else if (pick < 82) kind = SEQ_READS;
            else if (pick < 92) kind = SEQ_NOISE;
            else if (pick < 95) kind = SEQ_DIVE;
            else kind = SEQ_UNWIND;
            case (kind)
                SEQ_CALLS: begin
                    n = $urandom_range(4, 16);
                    repeat (n) begin
                        pick = $urandom_range(0, 99);
                        if (sb.level == 0 || (pick < 45 && sb.level < STACK_DEPTH))
                            send_item(FUNC_START, pick_task(), next_stamp());
                        else if (pick < 82)
                            send_item(FUNC_COMPLETE, 8'($urandom), next_stamp());
                        else
                            send_item(pick < 95 ? FUNC_READ : FUNC_UNUSED, pick_task(),
                                      next_stamp());
                    end
                end
                SEQ_READS: begin
                    repeat ($urandom_range(2, 6))
                        send_item($urandom_range(0, 1) ? FUNC_READ : FUNC_UNUSED,
                                  8'($urandom_range(0, 255)), rand48());
                end
                SEQ_NOISE: begin
                    repeat ($urandom_range(1, 3))
                        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                  rand48());
                end
                SEQ_DIVE: begin
                    while (sb.level < STACK_DEPTH)
                        send_item(FUNC_START, pick_task(), next_stamp());
                    repeat ($urandom_range(1, 2))
                        send_item(FUNC_START, pick_task(), next_stamp());
                    repeat ($urandom_range(1, STACK_DEPTH))
                        send_item(FUNC_COMPLETE, 8'($urandom), next_stamp());
                end
                default: begin
                    while (sb.level > 0)
                        send_item(FUNC_COMPLETE, 8'($urandom), next_stamp());
                    repeat ($urandom_range(1, 2))
                        send_item(FUNC_COMPLETE, 8'($urandom), next_stamp());
                end
            endcase
            seq_no++;
            if (!paused_once && items_sent >= 700) begin
                paused_once = 1'b1;
                wait_drained();
                @(negedge clk);
            end
        end

        wait_drained();
        repeat (20) @(negedge clk);
        sb.finish_check();
        $display("sent %0d events: %0d starts, %0d completes, %0d reads; %0d results checked",
                 items_sent, sb.n_start, sb.n_complete, sb.n_read, sb.checked);
        $display("deepest stack %0d, %0d full and %0d empty rejects, %0d capped sums",
                 sb.deepest, sb.n_full, sb.n_empty, sb.n_capped);
        if (sb.errors == 0) begin
            $display("flat_self_time_profiler_tb: clean");
        end else begin
            $display("%0d failures", sb.errors);
            $display("flat_self_time_profiler_tb: errors");
        end
        $finish;
    end

endmodule
